// ----- hw/rtl/msb_first_bit_packer_macros.svh -----
// Assertion macros for the MSB-first bit packer checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef MSB_FIRST_BIT_PACKER_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define MBP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packer check failed: same-cycle rule");

// Next-cycle implication, off while reset is asserted.
`define MBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packer check failed: next-cycle rule");

// Condition that must hold while reset is asserted.
`define MBP_ASSERT_IN_RESET(lbl, cons) \
	lbl: assert property (@(posedge clk) (!arst_n) |-> (cons)) \
		else $error("packer check failed: reset rule");

`endif

// ----- hw/rtl/mbp_pkg.sv -----
// Shared constants, types and width helpers for the MSB-first bit packer.
// No dependencies.
`default_nettype none
package mbp_pkg;

	localparam int MAX_FIELD_BITS_DEF = 32;
	localparam int COUNT_W            = 6;
	localparam int QUEUE_DEPTH        = 4;

	typedef enum logic {
		OP_PUT   = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	// input tdata: field bits, then the count, padded to whole bytes
	function automatic int tdata_w(input int max_bits);
		return ((max_bits + COUNT_W + 7) >> 3) << 3;
	endfunction

	// staged word: up to 7 pending bits ahead of a full field
	function automatic int word_w(input int max_bits);
		return max_bits + 8;
	endfunction

	function automatic int nbytes_w(input int max_bits);
		return $clog2(((max_bits + 7) >> 3) + 1);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mbp_front.sv -----
// Front end: accepts put and flush beats, merges them with the pending bits
// and hands whole-byte jobs to the queue. Depends on mbp_pkg.
`default_nettype none
module mbp_front #(
	parameter int MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF,
	localparam int TDATA_W = mbp_pkg::tdata_w(MAX_FIELD_BITS),
	localparam int WORD_W  = mbp_pkg::word_w(MAX_FIELD_BITS),
	localparam int NB_W    = mbp_pkg::nbytes_w(MAX_FIELD_BITS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,
	input  logic [0:0]           s_tuser,
	output logic                 job_push,
	output logic [WORD_W-1:0]    job_word,
	output logic [NB_W-1:0]      job_nbytes,
	input  logic                 job_full
);
	import mbp_pkg::*;

	localparam int CNTS_W = $clog2(MAX_FIELD_BITS + 1);
	localparam int TOT_W  = $clog2(MAX_FIELD_BITS + 8);

	// pending bits kept left aligned; bit 0 is always zero
	logic [7:0] pend_q;
	logic [2:0] pcnt_q;

	logic                      accept;
	logic                      is_flush;
	logic [MAX_FIELD_BITS-1:0] data;
	logic [COUNT_W-1:0]        cnt_in;
	logic [CNTS_W-1:0]         cnt_sat;
	logic [MAX_FIELD_BITS-1:0] data_m;
	logic [WORD_W-1:0]         word_put;
	logic [WORD_W-1:0]         word_rest;
	logic [TOT_W-1:0]          total;
	logic [NB_W-1:0]           nbytes_put;
	logic [7:0]                new_pend;
	logic [2:0]                new_cnt;

	assign s_tready = !job_full;
	assign accept   = s_tvalid && s_tready;
	assign is_flush = (op_t'(s_tuser[0]) == OP_FLUSH);
	assign data     = s_tdata[MAX_FIELD_BITS-1:0];
	assign cnt_in   = s_tdata[MAX_FIELD_BITS +: COUNT_W];

	always_comb begin
		if (32'(cnt_in) > 32'(MAX_FIELD_BITS)) begin
			cnt_sat = CNTS_W'(MAX_FIELD_BITS);
		end else begin
			cnt_sat = CNTS_W'(cnt_in);
		end
		data_m     = data & ~({MAX_FIELD_BITS{1'b1}} >> cnt_sat);
		word_put   = {pend_q, {MAX_FIELD_BITS{1'b0}}} | ({data_m, 8'h00} >> pcnt_q);
		total      = TOT_W'(pcnt_q) + TOT_W'(cnt_sat);
		nbytes_put = NB_W'(total >> 3);
		new_cnt    = total[2:0];
		// drop the bytes that leave now; what is left at the top stays pending
		word_rest  = word_put << {nbytes_put, 3'b000};
		new_pend   = word_rest[WORD_W-1 -: 8];
	end

	always_comb begin
		if (is_flush) begin
			job_word   = {pend_q, {MAX_FIELD_BITS{1'b0}}};
			job_nbytes = (pcnt_q != 3'd0) ? NB_W'(1) : NB_W'(0);
		end else begin
			job_word   = word_put;
			job_nbytes = nbytes_put;
		end
		job_push = accept && (job_nbytes != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 8'h00;
			pcnt_q <= 3'd0;
		end else if (accept) begin
			if (is_flush) begin
				pend_q <= 8'h00;
				pcnt_q <= 3'd0;
			end else begin
				pend_q <= new_pend;
				pcnt_q <= new_cnt;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/mbp_queue.sv -----
// Small job queue between the front end and the byte serializer.
// Depends on mbp_pkg for the default depth.
`default_nettype none
module mbp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mbp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);
	import mbp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/mbp_back.sv -----
// Back end: takes jobs from the queue and sends their bytes one beat per
// cycle while m_tready is high, from a registered output stage. Depends on mbp_pkg.
`default_nettype none
module mbp_back #(
	parameter int MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF,
	localparam int WORD_W = mbp_pkg::word_w(MAX_FIELD_BITS),
	localparam int NB_W   = mbp_pkg::nbytes_w(MAX_FIELD_BITS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  logic [WORD_W-1:0] job_word,
	input  logic [NB_W-1:0]   job_nbytes,
	output logic              job_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);
	import mbp_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic [NB_W-1:0]   rem_q;
	logic              take;
	logic              load;

	assign m_tvalid = (rem_q != '0);
	assign m_tlast  = (rem_q == NB_W'(1));
	assign m_tdata  = word_q[WORD_W-1 -: 8];
	assign take     = m_tvalid && m_tready;
	// refill as the final byte leaves, so queued items go out without a gap
	assign load     = job_valid && (!m_tvalid || (take && m_tlast));
	assign job_pop  = load;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= job_word;
		end else if (take) begin
			word_q <= word_q << 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= job_nbytes;
		end else if (take) begin
			rem_q <= rem_q - NB_W'(1);
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/msb_first_bit_packer.sv -----
// Top level of the MSB-first bit packer: front end, job queue, serializer.
// Depends on mbp_pkg, mbp_front, mbp_queue and mbp_back.
//
//   channel | direction | tdata                          | tuser     | tlast
//   s_      | in        | data_bits, bit_count, zero pad | operation | -
//   m_      | out       | out_byte                       | -         | last_byte
//
// The front end takes one beat per cycle while the queue has room; the pending
// bits update in the same cycle, so beats can follow back to back.
// Each item leaves as 0 to (MAX_FIELD_BITS+7)/8 output beats, one per cycle
// while m_tready is high (up to 4 for 32-bit fields); one byte port sets the rate.
// Reset clears the pending bits, the queue and the output stage.
// Output stalls fill the queue; s_tready drops only when it is full.
`default_nettype none
module msb_first_bit_packer #(
	parameter int MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF,
	localparam int TDATA_W = mbp_pkg::tdata_w(MAX_FIELD_BITS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // data_bits, bit_count, zero pad
	input  logic [0:0]         s_tuser,  // operation
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,  // out_byte
	output logic               m_tlast
);
	import mbp_pkg::*;

	localparam int WORD_W = word_w(MAX_FIELD_BITS);
	localparam int NB_W   = nbytes_w(MAX_FIELD_BITS);
	localparam int JOB_W  = WORD_W + NB_W;

	logic              push;
	logic [WORD_W-1:0] push_word;
	logic [NB_W-1:0]   push_nbytes;
	logic              full;
	logic              pop;
	logic              pop_valid;
	logic [JOB_W-1:0]  pop_data;

	mbp_front #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.job_push   (push),
		.job_word   (push_word),
		.job_nbytes (push_nbytes),
		.job_full   (full)
	);

	mbp_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_nbytes, push_word}),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	mbp_back #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (pop_valid),
		.job_word   (pop_data[WORD_W-1:0]),
		.job_nbytes (pop_data[JOB_W-1:WORD_W]),
		.job_pop    (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/mbp_checker.sv -----
// Port-level checks for the MSB-first bit packer, bound to the top level.
// Depends on msb_first_bit_packer_macros.svh.
`default_nettype none
`include "msb_first_bit_packer_macros.svh"
module mbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// a stalled output beat holds
	`MBP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// bytes of one item leave without a gap
	`MBP_ASSERT_NEXT(a_item_burst, m_tvalid && m_tready && !m_tlast, m_tvalid)
	// an idle output stage means the queue has room
	`MBP_ASSERT_NOW(a_idle_ready, !m_tvalid, s_tready)
	// no beat shows during reset
	`MBP_ASSERT_IN_RESET(a_reset_quiet, !m_tvalid)

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (.*);
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for msb_first_bit_packer: drives put and flush beats,
// predicts the packed byte stream and checks every output beat in order.
// Depends on mbp_pkg and the packer RTL.
`timescale 1ns / 1ps

module tb_top;
	import mbp_pkg::*;

	localparam int FIELD_BITS  = MAX_FIELD_BITS_DEF;
	localparam int TDATA_W     = tdata_w(FIELD_BITS);
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;

	// Tracks the pending partial byte and the bytes still owed by the packer.
	class packed_byte_tracker;
		typedef struct packed {
			logic [7:0] value;
			logic       last;
		} byte_beat_t;

		byte_beat_t expected_bytes[$];
		logic [6:0] pend_bits;
		logic [2:0] pend_cnt;
		int         mismatches;

		function new();
			pend_bits  = '0;
			pend_cnt   = '0;
			mismatches = 0;
		endfunction

		function void push_byte(logic [7:0] value);
			byte_beat_t b;
			b.value = value;
			b.last  = 1'b0;
			expected_bytes.push_back(b);
		endfunction

		function void note_item(op_t op, logic [31:0] data_bits, logic [5:0] bit_count);
			logic [7:0] acc;
			int         cnt;
			int         take;
			int         produced;
			produced = 0;
			if (op == OP_FLUSH) begin
				if (pend_cnt != 3'd0) begin
					acc = {1'b0, pend_bits} << (4'd8 - {1'b0, pend_cnt});
					push_byte(acc);
					produced = 1;
				end
				pend_bits = '0;
				pend_cnt  = '0;
			end else begin
				acc  = {1'b0, pend_bits};
				cnt  = pend_cnt;
				take = (bit_count > FIELD_BITS) ? FIELD_BITS : int'(bit_count);
				for (int i = 0; i < take; i++) begin
					acc = {acc[6:0], data_bits[FIELD_BITS-1-i]};
					cnt++;
					if (cnt == 8) begin
						push_byte(acc);
						produced++;
						acc = '0;
						cnt = 0;
					end
				end
				pend_bits = acc[6:0];
				pend_cnt  = cnt[2:0];
			end
			if (produced > 0)
				expected_bytes[expected_bytes.size()-1].last = 1'b1;
		endfunction

		function void check_byte(logic [7:0] value, logic last);
			byte_beat_t exp_b;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("[%0t] unexpected beat: byte=%02h last=%0b", $realtime, value, last);
				return;
			end
			exp_b = expected_bytes.pop_front();
			if (value !== exp_b.value || last !== exp_b.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("[%0t] mismatch: expected byte=%02h last=%0b, got byte=%02h last=%0b",
						$realtime, exp_b.value, exp_b.last, value, last);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic [0:0]         s_tuser = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [7:0]         m_tdata;
	logic               m_tlast;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	packed_byte_tracker tracker = new();

	msb_first_bit_packer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// start low so the first rising edge comes after reset has taken hold
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Output side: check the beat taken at this edge, then pick the next ready.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_byte(m_tdata, m_tlast);
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin
		for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Hold valid across back-to-back beats; drop it only for a gap.
	task automatic send_item(op_t op, logic [31:0] data_bits, logic [5:0] bit_count);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(TDATA_W-FIELD_BITS-6){1'b0}}, bit_count, data_bits};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_item(op, data_bits, bit_count);
	endtask

	task automatic send_random_item();
		int         pick;
		logic [5:0] cnt;
		pick = $urandom_range(99);
		if (pick < 12) begin
			send_item(OP_FLUSH, $urandom, 6'($urandom));
		end else begin
			pick = $urandom_range(99);
			if (pick < 6)
				cnt = 6'd0;
			else if (pick < 14)
				cnt = 6'($urandom_range(63, 33));
			else if (pick < 22)
				cnt = 6'd32;
			else
				cnt = 6'($urandom_range(31, 1));
			send_item(OP_PUT, $urandom, cnt);
		end
	endtask

	// Stop sending until every owed byte has come out.
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 23;
		rx_idle_pct = 51;

		send_item(OP_FLUSH, 32'h0000_0000, 6'd0);   // nothing pending
		send_item(OP_PUT,   32'hFFFF_FFFF, 6'd32);
		send_item(OP_PUT,   32'h0000_0000, 6'd32);
		send_item(OP_PUT,   32'hFFFF_FFFF, 6'd0);   // zero count
		send_item(OP_PUT,   32'hA500_00C3, 6'd63);  // count saturates
		send_item(OP_PUT,   32'h1234_5678, 6'd33);
		send_item(OP_PUT,   32'h8000_0000, 6'd1);
		send_item(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);  // fields ignored on flush
		send_item(OP_PUT,   32'hFE00_0000, 6'd7);
		send_item(OP_PUT,   32'h8000_0000, 6'd1);
		send_item(OP_PUT,   32'h4000_0000, 6'd3);
		send_item(OP_PUT,   32'hDEAD_BEEF, 6'd32);
		send_item(OP_PUT,   32'hFFFF_FFFF, 6'd5);
		send_item(OP_PUT,   32'hC000_0000, 6'd2);
		send_item(OP_FLUSH, 32'h0000_0000, 6'd0);
		send_item(OP_FLUSH, 32'h5A5A_5A5A, 6'd17);
		send_item(OP_PUT,   32'h7FFF_FFFF, 6'd31);
		send_item(OP_PUT,   32'hAAAA_AAAA, 6'd32);
		send_item(OP_FLUSH, 32'h0000_0000, 6'd0);
		send_item(OP_PUT,   32'h5555_5555, 6'd9);
		send_item(OP_PUT,   32'h0000_0001, 6'd32);
		send_item(OP_PUT,   32'hFFFF_FFFE, 6'd31);
		send_item(OP_FLUSH, 32'hFFFF_FFFF, 6'd32);

		for (int i = 0; i < 120; i++)
			send_random_item();
		drain_outputs();

		tx_idle_pct = 51;
		rx_idle_pct = 23;
		for (int i = 0; i < 120; i++)
			send_random_item();
		drain_outputs();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < 120; i++)
			send_random_item();
		drain_outputs();
		repeat (16) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.expected_bytes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
